[rtl/core/three_axis_highpass_magnitude_defines.svh]
// Assertion macros for the three-axis high-pass magnitude block.
// Included by the top level; expects signals clock and reset in scope.
`ifndef THREE_AXIS_HIGHPASS_MAGNITUDE_DEFINES_SVH
`define THREE_AXIS_HIGHPASS_MAGNITUDE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define THM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define THM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/thm_pkg.sv]
// Shared widths, constants and types for the three-axis high-pass magnitude block.
// No dependencies.
package thm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int OUT_W      = SAMPLE_W + 1;
   localparam int MAG_W      = 17;
   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;
   localparam int OP_COUNT   = 2 * AXES;          // filter ops, then square ops
   localparam int OP_W       = $clog2(OP_COUNT + 1);

   localparam int SUM_W      = SAMPLE_W + 3;
   localparam int ABS_W      = SUM_W - 1;
   localparam int MUL_B_W    = (OUT_W > COEF_W) ? OUT_W : COEF_W;
   localparam int PROD_W     = ABS_W + MUL_B_W;
   localparam int SQ_W       = 2 * OUT_W;
   localparam int ACC_W      = SQ_W + 2;
   localparam int ROOT_W     = ACC_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int CNT_W      = $clog2(ROOT_W + 1);

   localparam logic [COEF_W-1:0] COEF_RESET  = COEF_W'(63054);
   localparam logic [ABS_W-1:0]  OUT_MAX_ABS = ABS_W'((1 << (OUT_W - 1)) - 1);
   localparam logic [ABS_W-1:0]  OUT_MIN_ABS = ABS_W'(1 << (OUT_W - 1));

   typedef struct packed {
      logic            valid;
      logic [OP_W-1:0] op;
      logic            neg;
   } mul_tag_type;

endpackage

[rtl/core/thm_mul.sv]
// Shared unsigned multiplier with registered product and operation tag.
// Depends on thm_pkg.
module thm_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  thm_pkg::mul_tag_type           issue,
   input  logic [thm_pkg::ABS_W-1:0]      mul_a,
   input  logic [thm_pkg::MUL_B_W-1:0]    mul_b,
   output thm_pkg::mul_tag_type           tag,
   output logic [thm_pkg::PROD_W-1:0]     prod
);
   import thm_pkg::*;

   mul_tag_type       tag_ff;
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= issue;
      end
      if (issue.valid) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
   end

   assign tag  = tag_ff;
   assign prod = prod_ff;

endmodule

[rtl/core/thm_isqrt.sv]
// Iterative integer square root, one result bit per cycle, truncating.
// Depends on thm_pkg.
module thm_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [thm_pkg::ACC_W-1:0]     radicand,
   output logic                          done,
   output logic [thm_pkg::ROOT_W-1:0]    root
);
   import thm_pkg::*;

   logic              run_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [ACC_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;

   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic              take;

   // bring down the next two radicand bits, try root*4+1
   always_comb begin
      rem_shift = {rem_ff[REM_W-3:0], rad_ff[ACC_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      take      = (rem_shift >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            rad_ff  <= {rad_ff[ACC_W-3:0], 2'b00};
            rem_ff  <= take ? (rem_shift - trial) : rem_shift;
            root_ff <= {root_ff[ROOT_W-2:0], take};
            cnt_ff  <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/core/three_axis_highpass_magnitude.sv]
// Three-axis high-pass filter with vector magnitude, one item at a time.
// From accept to rsp_valid: the shared multiplier forms three filter products, then three
// squares, pipelined one per cycle; then the root is launched, the bit-serial root runs, the
// root is taken and the result is registered.
// A new item is accepted only once the last result has been sent; the result side can stall it.
// Reset (synchronous): idle, no result pending, filter history zero, coefficient 63054.
`include "three_axis_highpass_magnitude_defines.svh"

module three_axis_highpass_magnitude (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [thm_pkg::COEF_W-1:0]          csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [thm_pkg::SAMPLE_W-1:0] req_accel_x,
   input  logic signed [thm_pkg::SAMPLE_W-1:0] req_accel_y,
   input  logic signed [thm_pkg::SAMPLE_W-1:0] req_accel_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [thm_pkg::OUT_W-1:0]    rsp_filtered_x,
   output logic signed [thm_pkg::OUT_W-1:0]    rsp_filtered_y,
   output logic signed [thm_pkg::OUT_W-1:0]    rsp_filtered_z,
   output logic [thm_pkg::MAG_W-1:0]           rsp_motion_magnitude
);
   import thm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILTER,
      ST_START,
      ST_ROOT,
      ST_SEND
   } state_type;

   state_type                  state_ff, state_in;
   logic [COEF_W-1:0]          coef_ff;
   logic signed [SAMPLE_W-1:0] x_ff  [AXES];
   logic signed [SAMPLE_W-1:0] px_ff [AXES];
   logic signed [OUT_W-1:0]    py_ff [AXES];
   logic [OP_W-1:0]            issue_ff;
   logic [ACC_W-1:0]           acc_ff;
   logic [MAG_W-1:0]           root_ff;
   logic                       rsp_valid_ff;
   logic signed [OUT_W-1:0]    rsp_fx_ff, rsp_fy_ff, rsp_fz_ff;
   logic [MAG_W-1:0]           rsp_mag_ff;

   logic                       accept;
   logic                       issuing;
   logic                       filt_op;
   logic [AXIS_W-1:0]          issue_axis;
   logic signed [SUM_W-1:0]    s;
   logic                       s_neg;
   logic [SUM_W-1:0]           s_abs;
   logic signed [OUT_W-1:0]    py_sel;
   logic [OUT_W-1:0]           py_abs;
   logic [ABS_W-1:0]           mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   mul_tag_type                mul_issue;
   mul_tag_type                mul_tag;
   logic [PROD_W-1:0]          mul_prod;

   logic                       wb_filt;
   logic                       wb_sq;
   logic                       wb_last;
   logic [AXIS_W-1:0]          wb_axis;
   logic [ABS_W-1:0]           p;
   logic [ABS_W-1:0]           ymag;
   logic [ABS_W-1:0]           yneg;
   logic signed [OUT_W-1:0]    y_new;
   logic                       out_free;

   logic                       sq_start;
   logic                       sq_done;
   logic [ROOT_W-1:0]          sq_root;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sq_start  = (state_ff == ST_START);

   // issue side: ops 0..2 filter an axis, ops 3..5 square the stored result
   always_comb begin
      issuing    = (state_ff == ST_FILTER) && (issue_ff < OP_W'(OP_COUNT));
      filt_op    = (issue_ff < OP_W'(AXES));
      issue_axis = filt_op ? issue_ff[AXIS_W-1:0] : AXIS_W'(issue_ff - OP_W'(AXES));
      s          = SUM_W'(py_ff[issue_axis]) + SUM_W'(x_ff[issue_axis])
                   - SUM_W'(px_ff[issue_axis]);
      s_neg      = s[SUM_W-1];
      s_abs      = s_neg ? -s : s;
      py_sel     = py_ff[issue_axis];
      py_abs     = py_sel[OUT_W-1] ? -py_sel : py_sel;
      mul_a      = filt_op ? s_abs[ABS_W-1:0] : ABS_W'(py_abs);
      mul_b      = filt_op ? MUL_B_W'(coef_ff) : MUL_B_W'(py_abs);
      mul_issue  = '{valid: issuing, op: issue_ff, neg: s_neg};
   end

   // writeback side: truncate toward zero, then saturate to the output range
   always_comb begin
      wb_filt = mul_tag.valid && (mul_tag.op < OP_W'(AXES));
      wb_sq   = mul_tag.valid && !(mul_tag.op < OP_W'(AXES));
      wb_last = mul_tag.valid && (mul_tag.op == OP_W'(OP_COUNT - 1));
      wb_axis = mul_tag.op[AXIS_W-1:0];
      p       = mul_prod[COEF_W +: ABS_W];
      if (mul_tag.neg) begin
         ymag  = (p > OUT_MIN_ABS) ? OUT_MIN_ABS : p;
         yneg  = -ymag;
         y_new = yneg[OUT_W-1:0];
      end else begin
         ymag  = (p > OUT_MAX_ABS) ? OUT_MAX_ABS : p;
         yneg  = '0;
         y_new = ymag[OUT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FILTER;
         end
         ST_FILTER: begin
            if (wb_last) state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sq_done) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   thm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .issue (mul_issue),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .tag   (mul_tag),
      .prod  (mul_prod)
   );

   thm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         coef_ff      <= COEF_RESET;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < AXES; k++) begin
            px_ff[k] <= '0;
            py_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) coef_ff <= csr_write_data;
         if (accept) begin
            x_ff[0]  <= req_accel_x;
            x_ff[1]  <= req_accel_y;
            x_ff[2]  <= req_accel_z;
            issue_ff <= '0;
            acc_ff   <= '0;
         end
         if (issuing) begin
            issue_ff <= issue_ff + OP_W'(1);
            if (filt_op) px_ff[issue_axis] <= x_ff[issue_axis];
         end
         if (wb_filt) py_ff[wb_axis] <= y_new;
         if (wb_sq) acc_ff <= acc_ff + ACC_W'(mul_prod[SQ_W-1:0]);
         if ((state_ff == ST_ROOT) && sq_done) root_ff <= sq_root[MAG_W-1:0];
         if ((state_ff == ST_SEND) && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_fx_ff    <= py_ff[0];
            rsp_fy_ff    <= py_ff[1];
            rsp_fz_ff    <= py_ff[2];
            rsp_mag_ff   <= root_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_filtered_x       = rsp_fx_ff;
   assign rsp_filtered_y       = rsp_fy_ff;
   assign rsp_filtered_z       = rsp_fz_ff;
   assign rsp_motion_magnitude = rsp_mag_ff;

   `THM_ASSERT(a_mul_wb_in_filter, mul_tag.valid |-> state_ff == ST_FILTER, "stray product")
   `THM_ASSERT(a_root_done_in_root, sq_done |-> state_ff == ST_ROOT, "stray root")
   `THM_ASSERT(a_clean_start, accept |=> req_stall && issue_ff == '0 && acc_ff == '0, "dirty start")
   `THM_ASSERT(a_rsp_send, $rose(rsp_valid_ff) |-> $past(state_ff == ST_SEND), "no send")
   `THM_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid_ff && state_ff == ST_IDLE, "not idle")

endmodule
